@@ rtl/hrhp_pkg.sv @@
`default_nettype none
package hrhp_pkg;

	localparam int LengthBits = 32;
	localparam int UrlBits    = 12;

	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChLf    = 8'h0a;
	localparam logic [7:0] ChSp    = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChVt    = 8'h0b;
	localparam logic [7:0] ChFf    = 8'h0c;
	localparam logic [7:0] ChSlash = 8'h2f;
	localparam logic [7:0] ChQuery = 8'h3f;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	localparam logic [127:0] WordGet     = "get";
	localparam logic [127:0] WordPost    = "post";
	localparam logic [127:0] WordVersion = "http/1.1";
	localparam logic [127:0] WordKeep    = "keep-alive";
	localparam logic [127:0] WordConn    = "connection:";
	localparam logic [127:0] WordClen    = "content-length:";
	localparam logic [127:0] WordHost    = "host:";

	// request flag bits
	localparam int RfPost  = 0;
	localparam int RfDyn   = 1;
	localparam int RfKeep  = 2;
	localparam int RfHost  = 3;
	localparam int RfQuery = 4;
	localparam int RfBad   = 5;

	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_URL     = 3'd1,
		PH_VERSION = 3'd2,
		PH_HEADER  = 3'd3,
		PH_BODY    = 3'd4,
		PH_HALT    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_CONN = 2'd1,
		KIND_CLEN = 2'd2,
		KIND_HOST = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OUT_DONE      = 2'd0,
		OUT_BAD       = 2'd1,
		OUT_MALFORMED = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} req_t;

	typedef struct packed {
		logic [1:0]            outcome;
		logic                  method;
		logic                  dynamic;
		logic                  keep_alive;
		logic                  host_seen;
		logic [LengthBits-1:0] body_length;
		logic [UrlBits-1:0]    url_length;
		logic                  directory_url;
	} res_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] idx;
		logic [3:0] flags;
		kind_t      kind;
		logic       line_empty;
		logic       saw_cr;
		logic [5:0] rflags;
		logic       slash;
	} ctl_t;

	localparam ctl_t CtlReset = '{phase: PH_METHOD, idx: 4'd0, flags: 4'hf,
		kind: KIND_NONE, line_empty: 1'b1, saw_cr: 1'b0, rflags: 6'd0, slash: 1'b0};

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == ChSp || b == ChTab;
	endfunction

	function automatic logic [3:0] bump(input logic [3:0] i);
		return (i != 4'hf) ? i + 4'd1 : 4'hf;
	endfunction

	// true when byte b, lower-cased, equals character i of a word of length n
	function automatic logic word_hit(input logic [127:0] w, input logic [4:0] n,
			input logic [3:0] i, input logic [7:0] b);
		logic [6:0] pos;
		pos = 7'((n - 5'd1 - {1'b0, i}) << 3);
		return ({1'b0, i} < n) && (to_lower(b) == w[pos +: 8]);
	endfunction

	function automatic logic [127:0] hdr_word(input logic [1:0] c);
		unique case (c)
			2'd0:    return WordConn;
			2'd1:    return WordClen;
			default: return WordHost;
		endcase
	endfunction

	function automatic logic [4:0] hdr_len(input logic [1:0] c);
		unique case (c)
			2'd0:    return 5'd11;
			2'd1:    return 5'd15;
			default: return 5'd5;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ rtl/http_request_header_parser.sv @@
// http request header parser, one request byte per beat
// input beats are registered, then each request's result is registered
// throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being taken, parser state updates in one pass
// reset: arst_n clears the parser to request-line start with no beats held
`default_nettype none
module http_request_header_parser import hrhp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	logic                  v_s1;
	req_t                  req_s1;
	ctl_t                  ctl_q, ctl_n;
	logic [LengthBits-1:0] accum_q, accum_n;
	logic [LengthBits-1:0] remain_q, remain_n;
	logic [UrlBits-1:0]    ucnt_q, ucnt_n;
	logic                  fire;
	res_t                  res_n;
	logic                  out_free;
	logic                  adv;

	assign out_free  = !res_valid || !res_stall;
	assign adv       = v_s1 && out_free;
	assign req_stall = v_s1 && !out_free;

	hrhp_step u_step (
		.req_b    (req_s1),
		.ctl      (ctl_q),
		.accum    (accum_q),
		.remain   (remain_q),
		.ucnt     (ucnt_q),
		.ctl_n    (ctl_n),
		.accum_n  (accum_n),
		.remain_n (remain_n),
		.ucnt_n   (ucnt_n),
		.fire     (fire),
		.res_n    (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			res_valid <= 1'b0;
			ctl_q     <= CtlReset;
			accum_q   <= '0;
			remain_q  <= '0;
			ucnt_q    <= '0;
		end else begin
			if (!req_stall) v_s1 <= req_valid;
			if (adv) begin
				ctl_q    <= ctl_n;
				accum_q  <= accum_n;
				remain_q <= remain_n;
				ucnt_q   <= ucnt_n;
			end
			if (out_free) res_valid <= adv && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) req_s1 <= req;
		if (adv && fire) res <= res_n;
	end

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> v_s1 && res_valid && res_stall)
		else $error("input stalled with no held beat");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase != 3'd6 && ctl_q.phase != 3'd7)
		else $error("parser phase out of range");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.outcome != OUT_DONE |-> res.body_length == '0 && res.url_length == '0)
		else $error("failed request carries fields");

	a_halt_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) && res.outcome != OUT_DONE |-> ctl_q.phase == PH_HALT)
		else $error("parser not halted after failure");

endmodule
`default_nettype wire

@@ rtl/hrhp_step.sv @@
`default_nettype none
module hrhp_step import hrhp_pkg::*; (
	input  wire req_t                  req_b,
	input  wire ctl_t                  ctl,
	input  wire logic [LengthBits-1:0] accum,
	input  wire logic [LengthBits-1:0] remain,
	input  wire logic [UrlBits-1:0]    ucnt,
	output ctl_t                  ctl_n,
	output logic [LengthBits-1:0] accum_n,
	output logic [LengthBits-1:0] remain_n,
	output logic [UrlBits-1:0]    ucnt_n,
	output logic                  fire,
	output res_t                  res_n
);

	localparam logic [LengthBits-1:0] LenMax = '1;
	localparam logic [UrlBits-1:0]    UrlMax = '1;

	always_comb begin
		ctl_t                s;
		logic [LengthBits-1:0] a;
		logic [LengthBits-1:0] r;
		logic [UrlBits-1:0]    u;
		logic [7:0]            b;
		logic                  done;
		logic                  hit;
		logic [1:0]            fail;
		logic [LengthBits+3:0] prod;
		b    = req_b.data_byte;
		s    = req_b.restart ? CtlReset : ctl;
		a    = req_b.restart ? '0 : accum;
		r    = req_b.restart ? '0 : remain;
		u    = req_b.restart ? '0 : ucnt;
		done = 1'b0;
		hit  = 1'b0;
		fail = OUT_DONE;
		prod = '0;

		if (s.phase == PH_BODY) begin
			if (r != '0) r = r - 1'b1;
			if (r == '0) done = 1'b1;
		end else if (s.phase == PH_HALT) begin
			s = s;
		end else if (s.saw_cr) begin
			s.saw_cr = 1'b0;
			if (b != ChLf) begin
				fail = OUT_MALFORMED;
			end else if (s.phase == PH_VERSION) begin
				if (s.rflags[RfBad] || !s.flags[0] || s.idx != 4'd8) begin
					fail = OUT_BAD;
				end else begin
					s.phase = PH_HEADER;
					s.kind = KIND_NONE;
					s.flags = 4'h7;
					s.idx = 4'd0;
					s.line_empty = 1'b1;
				end
			end else if (s.phase != PH_HEADER) begin
				fail = OUT_BAD;
			end else if (s.line_empty) begin
				if (a != '0) begin
					s.phase = PH_BODY;
					r = a;
				end else begin
					done = 1'b1;
				end
			end else begin
				if (s.kind == KIND_CONN && s.flags == 4'h1 && s.idx == 4'd10)
					s.rflags[RfKeep] = 1'b1;
				s.kind = KIND_NONE;
				s.flags = 4'h7;
				s.idx = 4'd0;
				s.line_empty = 1'b1;
			end
		end else if (b == ChCr) begin
			s.saw_cr = 1'b1;
		end else if (b == ChLf) begin
			fail = OUT_MALFORMED;
		end else begin
			s.line_empty = 1'b0;
			unique case (s.phase)
				PH_METHOD: begin
					if (is_blank(b)) begin
						if (s.flags[0] && s.idx == 4'd3) s.rflags[RfPost] = 1'b0;
						else if (s.flags[1] && s.idx == 4'd4) begin
							s.rflags[RfPost] = 1'b1;
							s.rflags[RfDyn] = 1'b1;
						end else s.rflags[RfBad] = 1'b1;
						s.phase = PH_URL;
						s.idx = 4'd0;
					end else begin
						if (!word_hit(WordGet, 5'd3, s.idx, b)) s.flags[0] = 1'b0;
						if (!word_hit(WordPost, 5'd4, s.idx, b)) s.flags[1] = 1'b0;
						s.idx = bump(s.idx);
					end
				end
				PH_URL: begin
					if (is_blank(b)) begin
						if (s.idx == 4'd0) s.rflags[RfBad] = 1'b1;
						s.phase = PH_VERSION;
						s.idx = 4'd0;
						s.flags = 4'h1;
					end else begin
						if (s.idx == 4'd0 && b != ChSlash) s.rflags[RfBad] = 1'b1;
						s.idx = 4'd1;
						s.slash = (b == ChSlash);
						if (!s.rflags[RfQuery]) begin
							if (b == ChQuery && !s.rflags[RfPost]) begin
								s.rflags[RfQuery] = 1'b1;
								s.rflags[RfDyn] = 1'b1;
							end else if (u != UrlMax) u = u + 1'b1;
						end
					end
				end
				PH_VERSION: begin
					if (!word_hit(WordVersion, 5'd8, s.idx, b)) s.flags[0] = 1'b0;
					s.idx = bump(s.idx);
				end
				default: begin
					priority case (s.kind)
						KIND_CONN: begin
							if (s.flags[0] || !is_blank(b)) begin
								s.flags[0] = 1'b1;
								if (!word_hit(WordKeep, 5'd10, s.idx, b)) s.flags[1] = 1'b1;
								s.idx = bump(s.idx);
							end
						end
						KIND_CLEN: begin
							if (!s.flags[1]) begin
								if (!s.flags[0] && (is_blank(b) || b == ChVt || b == ChFf)) begin
									s = s;
								end else if (!s.flags[0] && (b == ChPlus || b == ChMinus)) begin
									s.flags[0] = 1'b1;
									if (b == ChMinus) s.flags[2] = 1'b1;
								end else begin
									s.flags[0] = 1'b1;
									if (b >= ChZero && b <= ChNine) begin
										if (!s.flags[2]) begin
											// a*10 + digit, clamp on overflow
											prod = ({4'd0, a} << 3) + ({4'd0, a} << 1)
												+ (LengthBits+4)'(b - ChZero);
											a = (prod > {4'd0, LenMax}) ? LenMax
												: prod[LengthBits-1:0];
										end
									end else begin
										s.flags[1] = 1'b1;
									end
								end
							end
						end
						KIND_HOST: s = s;
						default: begin
							if (s.flags[2:0] != 3'd0) begin
								for (int c = 0; c < 3; c++) begin
									if (!hit && s.flags[c]) begin
										if (!word_hit(hdr_word(2'(c)), hdr_len(2'(c)), s.idx, b))
											s.flags[c] = 1'b0;
										else if ({1'b0, s.idx} + 5'd1 == hdr_len(2'(c))) begin
											hit = 1'b1;
											s.kind = kind_t'(2'(c + 1));
											s.flags = 4'h0;
											s.idx = 4'd0;
											if (c == 1) a = '0;
											if (c == 2) s.rflags[RfHost] = 1'b1;
										end
									end
								end
								if (!hit) s.idx = bump(s.idx);
							end
						end
					endcase
				end
			endcase
		end

		fire  = done || (fail != OUT_DONE);
		res_n = '0;
		if (fail != OUT_DONE) begin
			res_n.outcome = fail;
			s.phase = PH_HALT;
		end else if (done) begin
			res_n.outcome        = OUT_DONE;
			res_n.method         = s.rflags[RfPost];
			res_n.dynamic        = s.rflags[RfDyn];
			res_n.keep_alive     = s.rflags[RfKeep];
			res_n.host_seen      = s.rflags[RfHost];
			res_n.body_length    = a;
			res_n.url_length     = u;
			res_n.directory_url  = s.slash;
			s = CtlReset;
			a = '0;
			r = '0;
			u = '0;
		end
		ctl_n    = s;
		accum_n  = a;
		remain_n = r;
		ucnt_n   = u;
	end

endmodule
`default_nettype wire
